// ----- hw/rtl/dsct_pkg.sv -----
// dsct_pkg: shared types, constants and the arctangent table function
// for the degree sine/cosine/tangent block. No dependencies.
package dsct_pkg;

    localparam int WB = 40;
    localparam int XW = 44;
    localparam int ZW = 42;
    localparam int QB = 33;
    localparam int DW = XW + QB;

    localparam logic [63:0] PI_Q60      = 64'h3243F6A8885A308D;
    localparam logic [63:0] DEG2RAD_Q60 = PI_Q60 / 64'd180;
    localparam logic signed [XW-1:0] GAIN_Q40 = XW'(40'h9B74EDA800);

    localparam logic [1:0] OP_SIN = 2'd0;
    localparam logic [1:0] OP_COS = 2'd1;
    localparam logic [1:0] OP_TAN = 2'd2;

    typedef struct packed {
        logic signed [31:0] angle_deg;
        logic [1:0]         operation;
    } in_t;

    typedef struct packed {
        logic signed [31:0] value;
        logic               undefined;
        logic               saturated;
    } out_t;

    typedef struct packed {
        logic signed [ZW-1:0] z;
        logic [1:0]           quad;
        logic                 neg;
        logic [1:0]           op;
        logic                 rm_zero;
    } mid_t;

    // atan(2^-i), 40 fractional bits, series evaluated at elaboration
    function automatic logic signed [63:0] atan_q40(input int i);
        logic signed [63:0] acc;
        logic signed [63:0] t;
        int                 m;
        acc = 64'sd0;
        if (i == 0)
        begin
            acc = $signed(PI_Q60 >> 22);
        end
        else
        begin
            for (int k = 0; k < 32; k++)
            begin
                m = 2 * k + 1;
                if (m * i <= 62)
                begin
                    t = $signed((64'd1 << (62 - m * i)) / 64'(m));
                    if (k % 2 == 1)
                    begin
                        acc = acc - t;
                    end
                    else
                    begin
                        acc = acc + t;
                    end
                end
            end
            acc = (acc + 64'sd2097152) >>> 22;
        end
        return acc;
    endfunction

endpackage

// ----- hw/rtl/dsct_fifo.sv -----
// dsct_fifo: small register FIFO with push/full and pop/empty sides.
// Generic; no package dependency.
module dsct_fifo #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 4
) (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             push,
    output logic             full,
    input  logic [WIDTH-1:0] din,
    input  logic             pop,
    output logic             empty,
    output logic [WIDTH-1:0] dout
);
    localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;

    logic [WIDTH-1:0] mem_reg [0:DEPTH-1];
    logic [AW-1:0]    wr_reg;
    logic [AW-1:0]    rd_reg;
    logic [AW:0]      cnt_reg;
    logic             wr_en;
    logic             rd_en;

    assign full  = (cnt_reg == (AW+1)'(DEPTH));
    assign empty = (cnt_reg == '0);
    assign wr_en = push & ~full;
    assign rd_en = pop & ~empty;
    assign dout  = mem_reg[rd_reg];

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem_reg[wr_reg] <= din;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_reg  <= '0;
            rd_reg  <= '0;
            cnt_reg <= '0;
        end
        else
        begin
            if (wr_en)
            begin
                wr_reg <= (wr_reg == AW'(DEPTH - 1)) ? '0 : wr_reg + 1'b1;
            end
            if (rd_en)
            begin
                rd_reg <= (rd_reg == AW'(DEPTH - 1)) ? '0 : rd_reg + 1'b1;
            end
            if (wr_en && !rd_en)
            begin
                cnt_reg <= cnt_reg + 1'b1;
            end
            else if (rd_en && !wr_en)
            begin
                cnt_reg <= cnt_reg - 1'b1;
            end
        end
    end

endmodule

// ----- hw/rtl/dsct_front.sv -----
// dsct_front: angle reduction to quadrant plus remainder, remainder to radians.
// Uses dsct_pkg types and constants.
module dsct_front #(
    parameter int ANGLE_FRAC_BITS = 16
) (
    input  logic            clk,
    input  logic            rst_n,
    input  logic            push,
    output logic            full,
    input  dsct_pkg::in_t   item,
    output logic            mid_push,
    input  logic            mid_full,
    output dsct_pkg::mid_t  mid_item
);
    localparam int F   = ANGLE_FRAC_BITS;
    localparam int MIW = 33 - F;
    localparam int PW1 = MIW + 26;
    localparam int NW  = PW1 - 32;
    localparam int RW  = F + 7;
    localparam int PW3 = RW + 32;
    localparam int PW4 = RW + 64;
    localparam int ZW  = dsct_pkg::ZW;
    localparam logic [25:0]   RECIP = 26'd47721859;
    localparam logic [RW-1:0] D90   = RW'(90) << F;
    localparam logic [31:0]   K_LO  = dsct_pkg::DEG2RAD_Q60[31:0];
    localparam logic [31:0]   K_HI  = dsct_pkg::DEG2RAD_Q60[63:32];

    logic en;

    logic           v1_reg, neg1_reg;
    logic [1:0]     op1_reg;
    logic [32:0]    mag1_reg;
    logic [PW1-1:0] prod1_reg;

    logic           v2_reg, neg2_reg, rneg2_reg;
    logic [1:0]     op2_reg, quad2_reg;
    logic [RW-1:0]  rm2_reg;

    logic           v3_reg, neg3_reg, rneg3_reg, rmz3_reg;
    logic [1:0]     op3_reg, quad3_reg;
    logic [PW3-1:0] pl3_reg, ph3_reg;

    logic           v4_reg;
    dsct_pkg::mid_t mid4_reg;

    logic           neg_c;
    logic [32:0]    mag_c;
    logic [MIW-1:0] mint_c;
    logic [PW1-1:0] prod_c;

    logic [NW-1:0]  n_c;
    logic [32:0]    nd_c;
    logic [32:0]    remw_c;
    logic [RW-1:0]  rem_c;
    logic [RW:0]    twice_c;
    logic           up_c;
    logic [RW-1:0]  rm_c;

    logic [PW4-1:0]       sum_c;
    logic signed [ZW-1:0] zmag_c;
    dsct_pkg::mid_t       mid_c;

    assign en       = ~mid_full;
    assign full     = mid_full;
    assign mid_push = v4_reg & en;
    assign mid_item = mid4_reg;

    always_comb
    begin
        neg_c  = item.angle_deg[31];
        mag_c  = neg_c ? (33'h1_0000_0000 - {1'b0, item.angle_deg})
                       : {1'b0, item.angle_deg};
        mint_c = mag_c[32:F];
        prod_c = PW1'(mint_c) * PW1'(RECIP);
    end

    always_comb
    begin
        n_c     = prod1_reg[PW1-1:32];
        nd_c    = 33'(n_c) * 33'd90;
        remw_c  = mag1_reg - (nd_c << F);
        rem_c   = remw_c[RW-1:0];
        twice_c = {rem_c, 1'b0};
        up_c    = (twice_c > {1'b0, D90}) || ((twice_c == {1'b0, D90}) && n_c[0]);
        rm_c    = up_c ? (D90 - rem_c) : rem_c;
    end

    always_comb
    begin
        sum_c  = PW4'(pl3_reg) + (PW4'(ph3_reg) << 32);
        zmag_c = ZW'(sum_c >> (F + 20));
        mid_c.z       = rneg3_reg ? -zmag_c : zmag_c;
        mid_c.quad    = quad3_reg;
        mid_c.neg     = neg3_reg;
        mid_c.op      = op3_reg;
        mid_c.rm_zero = rmz3_reg;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v1_reg <= 1'b0;
            v2_reg <= 1'b0;
            v3_reg <= 1'b0;
            v4_reg <= 1'b0;
        end
        else if (en)
        begin
            v1_reg <= push;
            v2_reg <= v1_reg;
            v3_reg <= v2_reg;
            v4_reg <= v3_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            neg1_reg  <= neg_c;
            op1_reg   <= item.operation;
            mag1_reg  <= mag_c;
            prod1_reg <= prod_c;

            neg2_reg  <= neg1_reg;
            op2_reg   <= op1_reg;
            rneg2_reg <= up_c;
            quad2_reg <= n_c[1:0] + {1'b0, up_c};
            rm2_reg   <= rm_c;

            neg3_reg  <= neg2_reg;
            op3_reg   <= op2_reg;
            rneg3_reg <= rneg2_reg;
            quad3_reg <= quad2_reg;
            rmz3_reg  <= (rm2_reg == '0);
            pl3_reg   <= PW3'(rm2_reg) * PW3'(K_LO);
            ph3_reg   <= PW3'(rm2_reg) * PW3'(K_HI);

            mid4_reg  <= mid_c;
        end
    end

endmodule

// ----- hw/rtl/dsct_back.sv -----
// dsct_back: pipelined CORDIC rotation, quadrant mapping, rounding and
// pipelined restoring divider for tangent. Uses dsct_pkg.
module dsct_back #(
    parameter int CORDIC_STAGES   = 24,
    parameter int ANGLE_FRAC_BITS = 16
) (
    input  logic            clk,
    input  logic            rst_n,
    input  logic            mid_empty,
    output logic            mid_pop,
    input  dsct_pkg::mid_t  mid_item,
    output logic            out_push,
    input  logic            out_full,
    output dsct_pkg::out_t  out_item
);
    localparam int N  = CORDIC_STAGES;
    localparam int F  = ANGLE_FRAC_BITS;
    localparam int XW = dsct_pkg::XW;
    localparam int ZW = dsct_pkg::ZW;
    localparam int DW = dsct_pkg::DW;
    localparam int QB = dsct_pkg::QB;
    localparam logic signed [XW+1:0] ONE  = (XW+2)'(1) <<< F;
    localparam logic signed [XW+1:0] HALF = (XW+2)'(1) <<< (39 - F);

    typedef struct packed {
        logic [1:0] quad;
        logic       neg;
        logic [1:0] op;
        logic       rm_zero;
    } cmeta_t;

    typedef struct packed {
        logic signed [31:0] val;
        logic               undef;
        logic               sat;
        logic               go;
        logic               rn;
        logic [XW-1:0]      ca;
        logic [DW-1:0]      rr;
        logic [QB-1:0]      qq;
    } dv_t;

    logic en;

    logic                 cv_reg [0:N];
    logic signed [XW-1:0] x_reg  [0:N];
    logic signed [XW-1:0] y_reg  [0:N];
    logic signed [ZW-1:0] z_reg  [0:N];
    cmeta_t               cm_reg [0:N];

    logic sv_reg;
    dv_t  sel_reg;
    logic dvv_reg [0:QB];
    dv_t  dv_reg  [0:QB];

    logic signed [XW:0] s_c, c_c, sn_c, cs_c, sa_c, ca_c;
    dv_t                sel_c;
    logic [DW-1:0]      lim_c;
    dv_t                chk_c;
    logic [QB:0]        qp_c;
    logic [QB-1:0]      qh_c;
    logic [QB-1:0]      tlim_c;
    dv_t                fin_c;

    function automatic logic signed [31:0] rnd(input logic signed [XW:0] v);
        logic signed [XW+1:0] t;
        t = (XW+2)'(v) + HALF;
        t = t >>> (40 - F);
        if (t > ONE)
        begin
            t = ONE;
        end
        if (t < -ONE)
        begin
            t = -ONE;
        end
        return 32'(t);
    endfunction

    assign en      = ~out_full;
    assign mid_pop = en & ~mid_empty;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cv_reg[0] <= 1'b0;
        end
        else if (en)
        begin
            cv_reg[0] <= ~mid_empty;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            x_reg[0]  <= dsct_pkg::GAIN_Q40;
            y_reg[0]  <= '0;
            z_reg[0]  <= mid_item.z;
            cm_reg[0] <= '{quad: mid_item.quad, neg: mid_item.neg,
                           op: mid_item.op, rm_zero: mid_item.rm_zero};
        end
    end

    for (genvar i = 0; i < N; i++)
    begin : g_cordic
        localparam logic signed [ZW-1:0] ATAN = ZW'(dsct_pkg::atan_q40(i));
        logic signed [XW-1:0] dx;
        logic signed [XW-1:0] dy;

        assign dx = y_reg[i] >>> i;
        assign dy = x_reg[i] >>> i;

        always_ff @(posedge clk or negedge rst_n)
        begin
            if (!rst_n)
            begin
                cv_reg[i+1] <= 1'b0;
            end
            else if (en)
            begin
                cv_reg[i+1] <= cv_reg[i];
            end
        end

        always_ff @(posedge clk)
        begin
            if (en)
            begin
                cm_reg[i+1] <= cm_reg[i];
                if (!z_reg[i][ZW-1])
                begin
                    x_reg[i+1] <= x_reg[i] - dx;
                    y_reg[i+1] <= y_reg[i] + dy;
                    z_reg[i+1] <= z_reg[i] - ATAN;
                end
                else
                begin
                    x_reg[i+1] <= x_reg[i] + dx;
                    y_reg[i+1] <= y_reg[i] - dy;
                    z_reg[i+1] <= z_reg[i] + ATAN;
                end
            end
        end
    end

    // quadrant mapping and sine/cosine rounding
    always_comb
    begin
        s_c = (XW+1)'(y_reg[N]);
        c_c = (XW+1)'(x_reg[N]);
        case (cm_reg[N].quad)
            2'd0:
            begin
                sn_c = s_c;
                cs_c = c_c;
            end
            2'd1:
            begin
                sn_c = c_c;
                cs_c = -s_c;
            end
            2'd2:
            begin
                sn_c = -s_c;
                cs_c = -c_c;
            end
            default:
            begin
                sn_c = -c_c;
                cs_c = s_c;
            end
        endcase
        if (cm_reg[N].neg)
        begin
            sn_c = -sn_c;
        end
        sa_c = sn_c[XW] ? -sn_c : sn_c;
        ca_c = cs_c[XW] ? -cs_c : cs_c;

        sel_c       = '0;
        sel_c.rn    = sn_c[XW] ^ cs_c[XW];
        sel_c.ca    = ca_c[XW-1:0];
        sel_c.rr    = DW'(sa_c[XW-1:0]);
        case (cm_reg[N].op)
            dsct_pkg::OP_SIN:
            begin
                sel_c.val = rnd(sn_c);
            end
            dsct_pkg::OP_COS:
            begin
                sel_c.val = rnd(cs_c);
            end
            dsct_pkg::OP_TAN:
            begin
                if (cm_reg[N].quad[0] && cm_reg[N].rm_zero)
                begin
                    sel_c.undef = 1'b1;
                end
                else if (ca_c == '0)
                begin
                    sel_c.sat = 1'b1;
                    sel_c.rn  = sn_c[XW];
                end
                else
                begin
                    sel_c.go = 1'b1;
                end
            end
            default:
            begin
                sel_c.val = '0;
            end
        endcase
    end

    // integer part overflow check, then seed the divider
    always_comb
    begin
        lim_c = (DW'(sel_reg.ca) << (31 - F)) + DW'(sel_reg.ca);
        chk_c = sel_reg;
        if (sel_reg.go && (sel_reg.rr >= lim_c))
        begin
            chk_c.go  = 1'b0;
            chk_c.sat = 1'b1;
        end
        chk_c.rr = sel_reg.rr << (F + 1);
        chk_c.qq = '0;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            sv_reg     <= 1'b0;
            dvv_reg[0] <= 1'b0;
        end
        else if (en)
        begin
            sv_reg     <= cv_reg[N];
            dvv_reg[0] <= sv_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            sel_reg   <= sel_c;
            dv_reg[0] <= chk_c;
        end
    end

    for (genvar k = 0; k < QB; k++)
    begin : g_div
        localparam int J = QB - 1 - k;
        logic [DW-1:0] t;
        dv_t           nx;

        always_comb
        begin
            t  = DW'(dv_reg[k].ca) << J;
            nx = dv_reg[k];
            if (dv_reg[k].rr >= t)
            begin
                nx.rr    = dv_reg[k].rr - t;
                nx.qq[J] = 1'b1;
            end
        end

        always_ff @(posedge clk or negedge rst_n)
        begin
            if (!rst_n)
            begin
                dvv_reg[k+1] <= 1'b0;
            end
            else if (en)
            begin
                dvv_reg[k+1] <= dvv_reg[k];
            end
        end

        always_ff @(posedge clk)
        begin
            if (en)
            begin
                dv_reg[k+1] <= nx;
            end
        end
    end

    // quotient rounding, range limit and sign
    always_comb
    begin
        fin_c  = dv_reg[QB];
        qp_c   = (QB+1)'(dv_reg[QB].qq) + (QB+1)'(1);
        qh_c   = qp_c[QB:1];
        tlim_c = dv_reg[QB].rn ? QB'(33'h0_8000_0000) : QB'(33'h0_7FFF_FFFF);
        if (dv_reg[QB].go)
        begin
            if (qh_c > tlim_c)
            begin
                fin_c.sat = 1'b1;
            end
            else
            begin
                fin_c.val = dv_reg[QB].rn ? -32'(qh_c) : 32'(qh_c);
            end
        end
        if (fin_c.sat)
        begin
            fin_c.val = fin_c.rn ? 32'sh8000_0000 : 32'sh7FFF_FFFF;
        end
        out_item.value     = fin_c.val;
        out_item.undefined = fin_c.undef;
        out_item.saturated = fin_c.sat;
    end

    assign out_push = en & dvv_reg[QB];

endmodule

// ----- hw/rtl/degree_sin_cos_tan.sv -----
// degree_sin_cos_tan: top level; front reduction, transaction queue, CORDIC and
// divider back end, result queue. Uses dsct_pkg, dsct_front, dsct_back, dsct_fifo.
//
//   channel   direction  handshake            payload
//   input     in         push / full          item   (dsct_pkg::in_t)
//   result    out        pop / empty          result (dsct_pkg::out_t)
//
// One transaction per cycle sustained while the result queue is not full. After
// acceptance a result passes 4 front stages, the middle queue, 1 load stage,
// CORDIC_STAGES rotation stages, 2 mapping stages, 33 divider stages, result queue.
// Reset clears valid bits and queue pointers only; no clearing pass.
// A full result queue stalls the back end only; the front keeps filling the
// middle queue until it is full, then full is raised.
module degree_sin_cos_tan #(
    parameter int CORDIC_STAGES   = 24,
    parameter int ANGLE_FRAC_BITS = 16
) (
    input  logic           clk,
    input  logic           rst_n,
    input  logic           push,
    output logic           full,
    input  dsct_pkg::in_t  item,
    output logic           empty,
    input  logic           pop,
    output dsct_pkg::out_t result
);
    localparam int MW = $bits(dsct_pkg::mid_t);
    localparam int OW = $bits(dsct_pkg::out_t);

    logic           mid_push, mid_full, mid_empty, mid_pop;
    dsct_pkg::mid_t mid_in, mid_out;
    logic [MW-1:0]  mid_dout;
    logic           out_push, out_full;
    dsct_pkg::out_t out_in;
    logic [OW-1:0]  out_dout;

    dsct_front #(
        .ANGLE_FRAC_BITS(ANGLE_FRAC_BITS)
    ) u_front (
        .clk      (clk),
        .rst_n    (rst_n),
        .push     (push),
        .full     (full),
        .item     (item),
        .mid_push (mid_push),
        .mid_full (mid_full),
        .mid_item (mid_in)
    );

    dsct_fifo #(
        .WIDTH(MW),
        .DEPTH(4)
    ) u_mid_q (
        .clk   (clk),
        .rst_n (rst_n),
        .push  (mid_push),
        .full  (mid_full),
        .din   (MW'(mid_in)),
        .pop   (mid_pop),
        .empty (mid_empty),
        .dout  (mid_dout)
    );

    assign mid_out = dsct_pkg::mid_t'(mid_dout);

    dsct_back #(
        .CORDIC_STAGES  (CORDIC_STAGES),
        .ANGLE_FRAC_BITS(ANGLE_FRAC_BITS)
    ) u_back (
        .clk       (clk),
        .rst_n     (rst_n),
        .mid_empty (mid_empty),
        .mid_pop   (mid_pop),
        .mid_item  (mid_out),
        .out_push  (out_push),
        .out_full  (out_full),
        .out_item  (out_in)
    );

    dsct_fifo #(
        .WIDTH(OW),
        .DEPTH(4)
    ) u_out_q (
        .clk   (clk),
        .rst_n (rst_n),
        .push  (out_push),
        .full  (out_full),
        .din   (OW'(out_in)),
        .pop   (pop),
        .empty (empty),
        .dout  (out_dout)
    );

    assign result = dsct_pkg::out_t'(out_dout);

endmodule
